// ===== hw/rtl/pls_pkg.sv =====
`timescale 1ns / 1ps

package pls_pkg;

  localparam int CAPACITY = 16;

  localparam int FUNC_W = 3;
  localparam int POS_W  = 8;
  localparam int DATA_W = 32;

  // request codes
  localparam logic [FUNC_W-1:0] FN_INSERT = 3'd0;
  localparam logic [FUNC_W-1:0] FN_REMOVE = 3'd1;
  localparam logic [FUNC_W-1:0] FN_READ   = 3'd2;
  localparam logic [FUNC_W-1:0] FN_ZERO   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_EMPTY  = 3'd4;

  // one memory access per cycle: one write, one registered read
  typedef struct packed {
    logic              we;
    logic [POS_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic [POS_W-1:0]  raddr;
  } mem_req_t;

  typedef struct packed {
    logic              ok;
    logic [DATA_W-1:0] rdata;
    logic [POS_W-1:0]  length;
  } result_t;

endpackage

// ===== hw/rtl/pls_mem.sv =====
`timescale 1ns / 1ps

module pls_mem #(
  parameter int CAPACITY = pls_pkg::CAPACITY
) (
  input  logic                          clk,
  input  pls_pkg::mem_req_t             req,
  output logic [pls_pkg::DATA_W-1:0]    rdata
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic [pls_pkg::DATA_W-1:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr[AW-1:0]] <= req.wdata;
    end
    rdata <= mem[req.raddr[AW-1:0]];
  end

endmodule

// ===== hw/rtl/pls_ctrl.sv =====
`timescale 1ns / 1ps

module pls_ctrl #(
  parameter int CAPACITY = pls_pkg::CAPACITY
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [pls_pkg::FUNC_W-1:0]    in_func,
  input  logic [pls_pkg::POS_W-1:0]     in_pos,
  input  logic [pls_pkg::DATA_W-1:0]    in_value,
  output logic                          ready,
  output pls_pkg::mem_req_t             mem_req,
  input  logic [pls_pkg::DATA_W-1:0]    mem_rdata,
  output logic                          res_valid,
  output pls_pkg::result_t              res,
  input  logic                          res_take
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = pls_pkg::POS_W;
  localparam int DW = pls_pkg::DATA_W;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_INS_RD = 3'd1;
  localparam logic [2:0] S_INS_WR = 3'd2;
  localparam logic [2:0] S_REM_RD = 3'd3;
  localparam logic [2:0] S_REM_WR = 3'd4;
  localparam logic [2:0] S_ZERO   = 3'd5;
  localparam logic [2:0] S_READ   = 3'd6;
  localparam logic [2:0] S_DONE   = 3'd7;

  logic [2:0]    state, state_next;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] lim, lim_next;
  logic [CW-1:0] count, count_next;
  logic [DW-1:0] val, val_next;
  logic          res_ok, res_ok_next;
  logic [DW-1:0] res_rdata, res_rdata_next;

  // shared unit: index step and index-vs-limit compare
  logic          at_lim;
  logic [CW-1:0] idx_dec, idx_inc;
  logic [PW-1:0] cnt_ext;
  logic [PW-1:0] cap_ext;

  assign at_lim  = (idx == lim);
  assign idx_dec = idx - 1'b1;
  assign idx_inc = idx + 1'b1;
  assign cnt_ext = PW'(count);
  assign cap_ext = PW'(CAPACITY);

  assign ready      = (state == S_IDLE);
  assign res_valid  = (state == S_DONE);
  assign res.ok     = res_ok;
  assign res.rdata  = res_rdata;
  assign res.length = cnt_ext;

  always_comb begin
    state_next     = state;
    idx_next       = idx;
    lim_next       = lim;
    count_next     = count;
    val_next       = val;
    res_ok_next    = res_ok;
    res_rdata_next = res_rdata;
    mem_req.we     = 1'b0;
    mem_req.waddr  = PW'(idx);
    mem_req.wdata  = val;
    mem_req.raddr  = PW'(idx);

    case (state)
      S_IDLE: begin
        mem_req.raddr = in_pos;
        if (in_valid) begin
          res_ok_next    = 1'b0;
          res_rdata_next = '0;
          val_next       = in_value;
          state_next     = S_DONE;
          case (in_func)
            pls_pkg::FN_INSERT: begin
              if (cnt_ext < cap_ext && in_pos <= cnt_ext) begin
                idx_next   = count;
                lim_next   = CW'(in_pos);
                state_next = S_INS_RD;
              end
            end
            pls_pkg::FN_REMOVE: begin
              if (in_pos < cnt_ext) begin
                idx_next   = CW'(in_pos);
                lim_next   = count - 1'b1;
                state_next = S_REM_RD;
              end
            end
            pls_pkg::FN_READ: begin
              if (in_pos < cnt_ext) begin
                state_next = S_READ;
              end
            end
            pls_pkg::FN_ZERO: begin
              idx_next   = '0;
              lim_next   = count;
              state_next = S_ZERO;
            end
            pls_pkg::FN_EMPTY: begin
              count_next  = '0;
              res_ok_next = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_INS_RD: begin
        if (at_lim) begin
          mem_req.we  = 1'b1;
          count_next  = count + 1'b1;
          res_ok_next = 1'b1;
          state_next  = S_DONE;
        end else begin
          mem_req.raddr = PW'(idx_dec);
          state_next    = S_INS_WR;
        end
      end
      S_INS_WR: begin
        mem_req.we    = 1'b1;
        mem_req.wdata = mem_rdata;
        idx_next      = idx_dec;
        state_next    = S_INS_RD;
      end
      S_REM_RD: begin
        if (at_lim) begin
          count_next  = count - 1'b1;
          res_ok_next = 1'b1;
          state_next  = S_DONE;
        end else begin
          mem_req.raddr = PW'(idx_inc);
          state_next    = S_REM_WR;
        end
      end
      S_REM_WR: begin
        mem_req.we    = 1'b1;
        mem_req.wdata = mem_rdata;
        idx_next      = idx_inc;
        state_next    = S_REM_RD;
      end
      S_ZERO: begin
        if (at_lim) begin
          res_ok_next = 1'b1;
          state_next  = S_DONE;
        end else begin
          mem_req.we    = 1'b1;
          mem_req.wdata = '0;
          idx_next      = idx_inc;
        end
      end
      S_READ: begin
        res_rdata_next = mem_rdata;
        res_ok_next    = 1'b1;
        state_next     = S_DONE;
      end
      S_DONE: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
    idx       <= idx_next;
    lim       <= lim_next;
    val       <= val_next;
    res_ok    <= res_ok_next;
    res_rdata <= res_rdata_next;
  end

endmodule

// ===== hw/rtl/positional_list_store.sv =====
`timescale 1ns / 1ps
// The result moves into the output register once the sequencer finishes and
// the output register is empty or its beat leaves; the output register lets a
// finished result wait while the next beat is taken.
// Reset (rst, synchronous, active high) empties the list and clears both
// handshakes; entry storage is not cleared.

module positional_list_store #(
  parameter int CAPACITY = pls_pkg::CAPACITY
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [pls_pkg::FUNC_W-1:0]    func,
  input  logic [pls_pkg::POS_W-1:0]     position,
  input  logic signed [pls_pkg::DATA_W-1:0] value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          ok,
  output logic signed [pls_pkg::DATA_W-1:0] read_value,
  output logic [pls_pkg::POS_W-1:0]     length
);

  pls_pkg::mem_req_t           mem_req;
  logic [pls_pkg::DATA_W-1:0]  mem_rdata;
  logic                        ready;
  logic                        res_valid;
  pls_pkg::result_t            res;
  logic                        res_take;

  // Entry storage: one write and one registered read each cycle. Every entry
  // move of insert/remove is a read followed by a write.
  pls_mem #(
    .CAPACITY (CAPACITY)
  ) u_mem (
    .clk   (clk),
    .req   (mem_req),
    .rdata (mem_rdata)
  );

  // Sequencer: one shared index stepper/comparator walks the entries.
  pls_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_func   (func),
    .in_pos    (position),
    .in_value  (value),
    .ready     (ready),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  assign in_stall = !ready;

  // output register: load when empty or when the current beat leaves
  assign res_take = res_valid && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (res_take) begin
      ok         <= res.ok;
      read_value <= res.rdata;
      length     <= res.length;
    end
  end

`ifndef SYNTH
  // the list never grows past its capacity
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (length <= CAPACITY))
    else $error("length beyond capacity");

  // a nonzero read value only comes with a successful operation
  a_rd_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && read_value != '0) |-> ok)
    else $error("read value without success");

  // one beat at a time: the block stalls right after taking a beat
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second beat taken while busy");
`endif

endmodule
